// ----- design/hcbp_pkg.sv -----
// hcbp_pkg: shared types, constants and helpers of the huffman code bit packer
// no dependencies; imported by every module of the block

package hcbp_pkg;

   localparam int WORD_BITS        = 64;
   localparam int LEN_W            = 7;
   localparam int SYM_W            = 8;
   localparam int SYMBOL_COUNT_DEF = 256;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_ENCODE = 2'd1,
      OP_FLUSH  = 2'd2
   } op_type;

   typedef struct packed {
      op_type               operation;
      logic [SYM_W-1:0]     symbol;
      logic [WORD_BITS-1:0] code_bits;
      logic [LEN_W-1:0]     code_length;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] packed_word;
      logic                 is_final;
   } rsp_type;

   // item handed from the lookup stage to the packing stage
   typedef struct packed {
      logic valid;
      logic flush;
   } ctl_type;

   function automatic logic [WORD_BITS-1:0] low_mask(input logic [LEN_W-1:0] n);
      low_mask = ~({WORD_BITS{1'b1}} << n);
   endfunction

endpackage

// ----- design/hcbp_table.sv -----
// hcbp_table: code and length memories with one write and one registered read port
// depends on hcbp_pkg

module hcbp_table import hcbp_pkg::*; #(
   parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(SYMBOL_COUNT)-1:0] wr_idx,
   input  logic [WORD_BITS-1:0]            wr_code,
   input  logic [LEN_W-1:0]                wr_len,
   input  logic                            rd_en,
   input  logic [$clog2(SYMBOL_COUNT)-1:0] rd_idx,
   output logic [WORD_BITS-1:0]            rd_code,
   output logic [LEN_W-1:0]                rd_len
);

   logic [WORD_BITS-1:0] code_mem_ff [SYMBOL_COUNT];
   logic [LEN_W-1:0]     len_mem_ff  [SYMBOL_COUNT];
   logic [WORD_BITS-1:0] rd_code_ff;
   logic [LEN_W-1:0]     rd_len_ff;
   logic [LEN_W-1:0]     wr_len_clip;

   // lengths above a word are stored as a full word
   assign wr_len_clip = (wr_len > LEN_W'(WORD_BITS)) ? LEN_W'(WORD_BITS) : wr_len;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         code_mem_ff[wr_idx] <= wr_code & low_mask(wr_len_clip);
         len_mem_ff[wr_idx]  <= wr_len_clip;
      end
      if (rd_en) begin
         rd_code_ff <= code_mem_ff[rd_idx];
         rd_len_ff  <= len_mem_ff[rd_idx];
      end
   end

   assign rd_code = rd_code_ff;
   assign rd_len  = rd_len_ff;

endmodule

// ----- design/hcbp_packer.sv -----
// hcbp_packer: bit accumulator, shift-merge of looked-up codes and result register
// depends on hcbp_pkg; fed by hcbp_table read data

module hcbp_packer import hcbp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_type              issue,
   input  logic [WORD_BITS-1:0] rd_code,
   input  logic [LEN_W-1:0]     rd_len,
   output logic                 stall,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data
);

   ctl_type              s1_ff, s1_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [LEN_W-1:0]     held_ff, held_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic [LEN_W:0]       sum;
   logic                 full;
   logic [LEN_W-2:0]     rest;
   logic [LEN_W-1:0]     space;
   logic                 len_zero;
   logic                 emit;
   logic                 fire;
   logic                 out_free;
   logic [WORD_BITS-1:0] word;

   always_comb begin
      sum      = {1'b0, held_ff} + {1'b0, rd_len};
      full     = (sum >= (LEN_W+1)'(WORD_BITS));
      rest     = sum[LEN_W-2:0];
      space    = LEN_W'(WORD_BITS) - held_ff;
      len_zero = (rd_len == '0);
      out_free = !rsp_valid_ff || rsp_ready;

      if (s1_ff.flush) begin
         emit = s1_ff.valid && (held_ff != '0);
         word = acc_ff << space;
      end else begin
         emit = s1_ff.valid && !len_zero && full;
         word = (acc_ff << space) | (rd_code >> rest);
      end

      stall = emit && !out_free;
      fire  = s1_ff.valid && !stall;
      s1_in = stall ? s1_ff : issue;

      acc_in  = acc_ff;
      held_in = held_ff;
      if (fire) begin
         if (s1_ff.flush) begin
            acc_in  = '0;
            held_in = '0;
         end else if (!len_zero) begin
            if (full) begin
               acc_in  = rd_code & low_mask({1'b0, rest});
               held_in = {1'b0, rest};
            end else begin
               acc_in  = (acc_ff << rd_len) | rd_code;
               held_in = sum[LEN_W-1:0];
            end
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit && out_free) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.packed_word = word;
         rsp_data_in.is_final = s1_ff.flush;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         acc_ff       <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_ff        <= s1_in;
         acc_ff       <= acc_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- design/huffman_code_bit_packer.sv -----
// huffman_code_bit_packer: top level, table lookup feeding the bit packer
// depends on hcbp_pkg, hcbp_table and hcbp_packer
//
//   channel   direction   handshake               beat
//   req       in          req_valid / req_ready   req_type (operation, symbol, code, length)
//   rsp       out         rsp_valid / rsp_ready   rsp_type (packed_word, is_final)
//
// one item per cycle while req_ready is high; the table read is registered, and
// the packing stage shift-merges it with the accumulator into the result register
// loads are written to the table at acceptance, so a following encode sees them
// reset clears the accumulator and the pipeline; table contents are undefined until loaded
// req_ready drops only while a result is waiting in the output register and the
// item in the packing stage has another result to give

module huffman_code_bit_packer import hcbp_pkg::*; #(
   parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(SYMBOL_COUNT);

   logic                 accept;
   logic                 in_range;
   logic                 wr_en;
   logic                 rd_en;
   logic [IDX_W-1:0]     idx;
   logic [WORD_BITS-1:0] rd_code;
   logic [LEN_W-1:0]     rd_len;
   logic                 stall;
   ctl_type              issue;

   assign accept   = req_valid && req_ready;
   assign in_range = ({1'b0, req_data.symbol} < (SYM_W+1)'(SYMBOL_COUNT));
   assign idx      = req_data.symbol[IDX_W-1:0];
   assign wr_en    = accept && in_range && (req_data.operation == OP_LOAD);
   assign rd_en    = accept && in_range && (req_data.operation == OP_ENCODE);

   assign issue.valid = rd_en || (accept && (req_data.operation == OP_FLUSH));
   assign issue.flush = (req_data.operation == OP_FLUSH);
   assign req_ready   = !stall;

   hcbp_table #(
      .SYMBOL_COUNT (SYMBOL_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (idx),
      .wr_code (req_data.code_bits),
      .wr_len  (req_data.code_length),
      .rd_en   (rd_en),
      .rd_idx  (idx),
      .rd_code (rd_code),
      .rd_len  (rd_len)
   );

   hcbp_packer u_packer (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .rd_code   (rd_code),
      .rd_len    (rd_len),
      .stall     (stall),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- design/hcbp_checker.sv -----
// hcbp_checker: port-level checks of the huffman code bit packer, bound to the top level
// depends on hcbp_pkg and huffman_code_bit_packer

module hcbp_checker import hcbp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // result register empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   // input back-pressure only comes from a blocked result
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a blocked result");

   // a fresh result traces back to an accepted item, through the packing stage and the result register
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a source beat");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (.*);
